// File: design/ptma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptma_pkg
// Shared types and constants for the polynomial term merge adder.
// ----------------------------------------------------------------------------
package ptma_pkg;

    localparam int PTMA_DEPTH = 32;

    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_RUN    = 2'd2;

    typedef struct packed {
        logic [7:0]         expo;
        logic signed [15:0] coeff;
    } t_term;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] coeff;
        logic [7:0]         expo;
    } t_in_beat;

    typedef struct packed {
        logic signed [16:0] sum_coeff;
        logic [7:0]         sum_expo;
        logic               is_empty;
        logic               dropped;
        logic               last;
    } t_out_beat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_stat;

endpackage
`default_nettype wire

// File: design/ptma_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptma_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ptma_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: design/ptma_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptma_merge
// Merge sequencer: walks both term tables through one compare/add unit and
// emits sum terms into an output register.
// ----------------------------------------------------------------------------
module ptma_merge
    import ptma_pkg::*;
#(
    parameter int DEPTH = PTMA_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [CW-1:0] i_cnt_a,
    input  wire logic [CW-1:0] i_cnt_b,
    input  wire logic          i_dropped,
    input  wire t_term         i_rd_a,
    input  wire t_term         i_rd_b,
    output logic [AW-1:0]      o_addr_a,
    output logic [AW-1:0]      o_addr_b,
    output t_seq_stat          o_stat,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output t_out_beat          o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_EMPTY
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_ia, n_ia;
    logic [CW-1:0]   r_ib, n_ib;
    logic            r_out_valid, n_out_valid;
    t_out_beat       r_out, n_out;
    logic            done;

    logic            has_a, has_b, sel_a, sel_b, out_free;
    logic [CW-1:0]   ia_adv, ib_adv;
    logic [16:0]     add_a, add_b;

    // compare/add unit
    always_comb begin
        has_a  = (r_ia < i_cnt_a);
        has_b  = (r_ib < i_cnt_b);
        sel_a  = has_a && (!has_b || (i_rd_a.expo >= i_rd_b.expo));
        sel_b  = has_b && (!has_a || (i_rd_b.expo >= i_rd_a.expo));
        add_a  = sel_a ? {i_rd_a.coeff[15], i_rd_a.coeff} : 17'd0;
        add_b  = sel_b ? {i_rd_b.coeff[15], i_rd_b.coeff} : 17'd0;
        ia_adv = r_ia + CW'(sel_a);
        ib_adv = r_ib + CW'(sel_b);
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_ia        = r_ia;
        n_ib        = r_ib;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        done        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_ia    = '0;
                    n_ib    = '0;
                    n_state = ((i_cnt_a == '0) && (i_cnt_b == '0)) ? S_EMPTY : S_READ;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.sum_coeff = add_a + add_b;
                    n_out.sum_expo  = sel_a ? i_rd_a.expo : i_rd_b.expo;
                    n_out.is_empty  = 1'b0;
                    n_out.dropped   = i_dropped;
                    n_out.last      = !(ia_adv < i_cnt_a) && !(ib_adv < i_cnt_b);
                    n_ia            = ia_adv;
                    n_ib            = ib_adv;
                    done            = n_out.last;
                    n_state         = n_out.last ? S_IDLE : S_READ;
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.sum_coeff = '0;
                    n_out.sum_expo  = '0;
                    n_out.is_empty  = 1'b1;
                    n_out.dropped   = i_dropped;
                    n_out.last      = 1'b1;
                    done            = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_ia  <= n_ia;
        r_ib  <= n_ib;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_addr_a    = r_ia[AW-1:0];
    assign o_addr_b    = r_ib[AW-1:0];
    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = done;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("run started while merge busy");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (r_out_valid && r_out.last && (r_state == S_IDLE)))
        else $error("run end without final beat");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.is_empty) |-> r_out.last)
        else $error("empty result not marked last");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ((r_ia <= i_cnt_a) && (r_ib <= i_cnt_b)
                                && ((r_ia < i_cnt_a) || (r_ib < i_cnt_b))))
        else $error("merge index out of range");

endmodule
`default_nettype wire

// File: design/polynomial_term_merge_add.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polynomial_term_merge_add
// Loads two descending-exponent term tables and emits their sorted sum.
// ----------------------------------------------------------------------------
//  channel  | valid       | ready       | payload
//  ---------+-------------+-------------+--------------------------------------
//  input    | i_in_valid  | o_in_ready  | i_in  (action, coeff, expo)
//  output   | o_out_valid | i_out_ready | o_out (sum_coeff, sum_expo, is_empty,
//           |             |             |        dropped, last)
//
//  a term past DEPTH is dropped and flagged
//  a run takes two steps per result term: ram read, then compare/add
//  a run on two empty tables gives one is_empty beat
//  o_in_ready is low for the whole run; output back-pressure holds the merge
//  reset clears counts, flag and sequencer; table contents are not cleared
// ----------------------------------------------------------------------------
module polynomial_term_merge_add
    import ptma_pkg::*;
#(
    parameter int DEPTH = PTMA_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in_beat i_in,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out_beat o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = $bits(t_term);

    logic [CW-1:0] r_cnt_a, n_cnt_a;
    logic [CW-1:0] r_cnt_b, n_cnt_b;
    logic          r_overflow, n_overflow;

    t_seq_stat     stat;
    logic          accept, we_a, we_b, start;
    logic [AW-1:0] addr_a, addr_b;
    t_term         wterm, rd_a, rd_b;

    assign o_in_ready = !stat.busy;
    assign accept     = i_in_valid && o_in_ready;
    assign wterm.expo  = i_in.expo;
    assign wterm.coeff = i_in.coeff;

    always_comb begin
        n_cnt_a    = r_cnt_a;
        n_cnt_b    = r_cnt_b;
        n_overflow = r_overflow;
        we_a       = 1'b0;
        we_b       = 1'b0;
        start      = 1'b0;
        if (accept) begin
            case (i_in.action)
                ACT_LOAD_A: begin
                    if (r_cnt_a < CW'(DEPTH)) begin
                        we_a    = 1'b1;
                        n_cnt_a = r_cnt_a + 1'b1;
                    end else begin
                        n_overflow = 1'b1;
                    end
                end
                ACT_LOAD_B: begin
                    if (r_cnt_b < CW'(DEPTH)) begin
                        we_b    = 1'b1;
                        n_cnt_b = r_cnt_b + 1'b1;
                    end else begin
                        n_overflow = 1'b1;
                    end
                end
                ACT_RUN: begin
                    start = 1'b1;
                end
                default: begin
                end
            endcase
        end
        // tables empty out when the final beat of a run is produced
        if (stat.done) begin
            n_cnt_a    = '0;
            n_cnt_b    = '0;
            n_overflow = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_cnt_a    <= n_cnt_a;
            r_cnt_b    <= n_cnt_b;
            r_overflow <= n_overflow;
        end
    end

    ptma_ram #(
        .WIDTH (TW),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (wterm),
        .i_raddr (addr_a),
        .o_rdata (rd_a)
    );

    ptma_ram #(
        .WIDTH (TW),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (wterm),
        .i_raddr (addr_b),
        .o_rdata (rd_b)
    );

    ptma_merge #(
        .DEPTH (DEPTH)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cnt_a     (r_cnt_a),
        .i_cnt_b     (r_cnt_b),
        .i_dropped   (r_overflow),
        .i_rd_a      (rd_a),
        .i_rd_b      (rd_b),
        .o_addr_a    (addr_a),
        .o_addr_b    (addr_b),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// File: test/tb_polynomial_term_merge_add.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polynomial_term_merge_add
// Self-checking bench for the polynomial term merge adder. Term tables are
// loaded and merged through the input channel. A local model of both tables
// predicts every sum term, and each output beat is checked against it.
// Coverage: extreme coefficients and exponents, zero sums, tails of either
// table, unsorted tables, table overflow, ignored actions and random term
// sets under three mixes of source and sink stalls.
// ----------------------------------------------------------------------------
module tb_polynomial_term_merge_add;
    import ptma_pkg::*;

    localparam int         DEPTH        = PTMA_DEPTH;
    localparam logic [1:0] ACT_NONE     = 2'd3;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         DRAIN_CYCLES = 16;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out;

    // model of the two term tables
    t_term     tab_a [DEPTH];
    t_term     tab_b [DEPTH];
    int        n_a      = 0;
    int        n_b      = 0;
    logic      ovf_flag = 1'b0;
    t_out_beat sum_terms_q [$];

    int        snd_idle_pct    = 0;
    int        rcv_idle_pct    = 0;
    int        items_sent      = 0;
    int        runs_sent       = 0;
    int        results_checked = 0;
    int        errors          = 0;
    t_out_beat want;

    polynomial_term_merge_add #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // update the tables for one accepted beat and queue the sum terms of a run
    task automatic merge_predict(input t_in_beat b);
        int        ia;
        int        ib;
        t_out_beat r;
        case (b.action)
            ACT_LOAD_A: begin
                if (n_a < DEPTH) begin
                    tab_a[n_a].coeff = b.coeff;
                    tab_a[n_a].expo  = b.expo;
                    n_a++;
                end else begin
                    ovf_flag = 1'b1;
                end
            end
            ACT_LOAD_B: begin
                if (n_b < DEPTH) begin
                    tab_b[n_b].coeff = b.coeff;
                    tab_b[n_b].expo  = b.expo;
                    n_b++;
                end else begin
                    ovf_flag = 1'b1;
                end
            end
            ACT_RUN: begin
                if (n_a == 0 && n_b == 0) begin
                    r          = '0;
                    r.is_empty = 1'b1;
                    r.dropped  = ovf_flag;
                    r.last     = 1'b1;
                    sum_terms_q.push_back(r);
                end else begin
                    ia = 0;
                    ib = 0;
                    while (ia < n_a || ib < n_b) begin
                        r         = '0;
                        r.dropped = ovf_flag;
                        if (ia < n_a && ib < n_b && tab_a[ia].expo == tab_b[ib].expo) begin
                            r.sum_coeff = {tab_a[ia].coeff[15], tab_a[ia].coeff}
                                        + {tab_b[ib].coeff[15], tab_b[ib].coeff};
                            r.sum_expo  = tab_a[ia].expo;
                            ia++;
                            ib++;
                        end else if (ib >= n_b
                                     || (ia < n_a && tab_a[ia].expo > tab_b[ib].expo)) begin
                            r.sum_coeff = {tab_a[ia].coeff[15], tab_a[ia].coeff};
                            r.sum_expo  = tab_a[ia].expo;
                            ia++;
                        end else begin
                            r.sum_coeff = {tab_b[ib].coeff[15], tab_b[ib].coeff};
                            r.sum_expo  = tab_b[ib].expo;
                            ib++;
                        end
                        r.last = (ia >= n_a && ib >= n_b);
                        sum_terms_q.push_back(r);
                    end
                end
                n_a      = 0;
                n_b      = 0;
                ovf_flag = 1'b0;
                runs_sent++;
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_beat(input logic [1:0] act, input logic signed [15:0] c,
                             input logic [7:0] e);
        t_in_beat b;
        b.action = act;
        b.coeff  = c;
        b.expo   = e;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= b;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        merge_predict(b);
        if (act != ACT_NONE) items_sent++;
    endtask

    // hold the source off until every predicted term has been seen
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sum_terms_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_coeff();
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0:       return 16'sh7fff;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                default: return 16'shffff;
            endcase
        end
        return 16'($urandom);
    endfunction

    task automatic chk_field(input string name, input logic signed [31:0] want_v,
                             input logic signed [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sum_terms_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %h", $time, o_out);
                errors++;
            end else begin
                want = sum_terms_q.pop_front();
                chk_field("sum_coeff", want.sum_coeff, o_out.sum_coeff);
                chk_field("sum_expo", want.sum_expo, o_out.sum_expo);
                chk_field("is_empty", want.is_empty, o_out.is_empty);
                chk_field("dropped", want.dropped, o_out.dropped);
                chk_field("last", want.last, o_out.last);
                results_checked++;
            end
        end
    end

    task automatic test_directed();
        snd_idle_pct = 36;
        rcv_idle_pct = 68;
        // run on two empty tables
        send_beat(ACT_RUN, 16'sh0000, 8'h00);
        // unused action leaves the tables alone
        send_beat(ACT_NONE, 16'sh1234, 8'h56);
        send_beat(ACT_RUN, 16'shffff, 8'hff);
        // largest and smallest sums at the exponent extremes
        send_beat(ACT_LOAD_A, 16'sh7fff, 8'hff);
        send_beat(ACT_LOAD_A, 16'sh8000, 8'h00);
        send_beat(ACT_LOAD_B, 16'sh7fff, 8'hff);
        send_beat(ACT_LOAD_B, 16'sh8000, 8'h00);
        send_beat(ACT_RUN, 16'sh0000, 8'h00);
        // zero sum kept, larger exponent passes, tail of b
        send_beat(ACT_LOAD_A, 16'sd5, 8'd10);
        send_beat(ACT_LOAD_B, -16'sd5, 8'd10);
        send_beat(ACT_LOAD_B, 16'sd7, 8'd7);
        send_beat(ACT_LOAD_A, 16'sd1, 8'd3);
        send_beat(ACT_LOAD_B, 16'sd2, 8'd1);
        send_beat(ACT_RUN, 16'sh0000, 8'h00);
        // tail of a after b runs out
        send_beat(ACT_LOAD_A, 16'sd1, 8'd200);
        send_beat(ACT_LOAD_B, 16'sd9, 8'd150);
        send_beat(ACT_LOAD_A, 16'sd2, 8'd100);
        send_beat(ACT_LOAD_A, 16'sd3, 8'd50);
        send_beat(ACT_RUN, 16'sh0000, 8'h00);
        // only b, loaded in ascending order
        send_beat(ACT_LOAD_B, -16'sd1, 8'h55);
        send_beat(ACT_LOAD_B, 16'sh5555, 8'haa);
        send_beat(ACT_RUN, 16'shaaaa, 8'h55);
    endtask

    task automatic test_overflow();
        snd_idle_pct = 68;
        rcv_idle_pct = 36;
        // one term past depth on each side, partly equal exponents
        for (int i = 0; i <= DEPTH; i++) begin
            send_beat(ACT_LOAD_A, rand_coeff(), 8'(255 - 2 * i));
            send_beat(ACT_LOAD_B, rand_coeff(), 8'(255 - 3 * i));
        end
        send_beat(ACT_RUN, 16'sh0000, 8'h00);
        // flag must be gone after the run
        send_beat(ACT_RUN, 16'sh0000, 8'h00);
    endtask

    task automatic test_random(input int snd_pct, input int rcv_pct, input int n_items);
        int    goal;
        int    k;
        int    e;
        int    where;
        int    step;
        bit    big;
        bit    unsorted;
        t_term t;
        t_term qa [$];
        t_term qb [$];
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            if ($urandom_range(99) < 6) begin
                send_beat(ACT_NONE, 16'($urandom), 8'($urandom));
            end else begin
                qa.delete();
                qb.delete();
                big      = ($urandom_range(99) < 4);
                unsorted = ($urandom_range(99) < 10);
                k        = big ? $urandom_range(70, 36) : $urandom_range(8, 0);
                e        = big ? 255 : $urandom_range(255, 0);
                step     = big ? 3 : ($urandom_range(1) ? 4 : 40);
                // descending walk; each point lands in a, b or both
                repeat (k) begin
                    t.coeff = rand_coeff();
                    t.expo  = unsorted ? 8'($urandom) : e[7:0];
                    where   = $urandom_range(2);
                    if (where != 1) qa.push_back(t);
                    if (where != 0) begin
                        t.coeff = rand_coeff();
                        qb.push_back(t);
                    end
                    e = e - $urandom_range(step, 0);
                    if (e < 0) e = 0;
                end
                while (qa.size() != 0 || qb.size() != 0) begin
                    if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(1) == 1)) begin
                        send_beat(ACT_LOAD_A, qa[0].coeff, qa[0].expo);
                        void'(qa.pop_front());
                    end else begin
                        send_beat(ACT_LOAD_B, qb[0].coeff, qb[0].expo);
                        void'(qb.pop_front());
                    end
                    if ($urandom_range(99) < 3) begin
                        send_beat(ACT_NONE, 16'($urandom), 8'($urandom));
                    end
                end
                // now and then the tables carry over into the next set
                if ($urandom_range(99) < 90) send_beat(ACT_RUN, rand_coeff(), 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: timeout with %0d terms outstanding", $time, sum_terms_q.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drain();
        test_overflow();
        wait_drain();
        test_random(36, 68, 50);
        wait_drain();
        test_random(68, 36, 40);
        wait_drain();
        test_random(0, 0, 40);
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d load and run beats over %0d merges, %0d sum terms compared",
                 items_sent, runs_sent, results_checked);
        $display("extremes, zero sums, tails, unsorted tables, overflow, stall mixes");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: files.f
design/ptma_pkg.sv
design/ptma_ram.sv
design/ptma_merge.sv
design/polynomial_term_merge_add.sv
test/tb_polynomial_term_merge_add.sv
